@@ src/discrete_log_search_defines.svh @@
// assertion macros shared by the discrete log search checkers
// no dependencies; expects clk and arst_n in the scope of each use
`ifndef DISCRETE_LOG_SEARCH_DEFINES_SVH
`define DISCRETE_LOG_SEARCH_DEFINES_SVH

// immediate implication in the same cycle
`define DLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// implication on the following cycle
`define DLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ src/dls_pkg.sv @@
// shared types for the discrete log search block
// result status codes and the controller to datapath command and status groups
package dls_pkg;

	typedef enum logic [1:0] {
		ST_FOUND      = 2'd0,
		ST_NOT_GEN    = 2'd1,
		ST_BAD_TARGET = 2'd2
	} status_t;

	typedef struct packed {
		logic    load;
		logic    init_p;
		logic    mul_start;
		logic    res_load;
		logic    res_found;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic bad_base;
		logic bad_target;
		logic p_one;
		logic p_eq_b;
		logic k_lt_last;
		logic k_le_last;
		logic mul_done;
	} sts_t;

endpackage

@@ src/dls_if.sv @@
// valid/ready channel interfaces for the discrete log search block
// request word carries modulus, base and target; response word status and exponent
interface dls_in_if #(parameter int WIDTH = 16);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] modulus;
	logic [WIDTH-1:0] base;
	logic [WIDTH-1:0] target;

	modport source (output valid, output modulus, output base, output target, input ready);
	modport sink (input valid, input modulus, input base, input target, output ready);
endinterface

interface dls_out_if #(parameter int WIDTH = 16);
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [WIDTH-1:0] exponent;

	modport source (output valid, output status, output exponent, input ready);
	modport sink (input valid, input status, input exponent, output ready);
endinterface

@@ src/dls_dp.sv @@
// datapath of the discrete log search: operand registers, power register,
// exponent counter, bit-serial modular multiplier and result register; uses dls_pkg
module dls_dp import dls_pkg::*; #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [WIDTH-1:0] modulus,
	input  logic [WIDTH-1:0] base,
	input  logic [WIDTH-1:0] target,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic [1:0]       status,
	output logic [WIDTH-1:0] exponent
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] n_q, g_q, b_q, p_q, k_q;
	logic [WIDTH-1:0] acc_q, gsh_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [1:0]       status_q;
	logic [WIDTH-1:0] exponent_q;

	logic [WIDTH-1:0] nm1;
	logic [WIDTH:0]   nx, dbl, red1, sum, red2, step;

	always_comb begin
		nm1  = n_q - WIDTH'(1);
		nx   = {1'b0, n_q};
		dbl  = {acc_q, 1'b0};
		red1 = (dbl >= nx) ? dbl - nx : dbl;
		sum  = red1 + {1'b0, p_q};
		red2 = (sum >= nx) ? sum - nx : sum;
		step = gsh_q[WIDTH-1] ? red2 : red1;
	end

	always_comb begin
		sts.bad_base   = (n_q < WIDTH'(2)) || (g_q >= n_q);
		sts.bad_target = (b_q >= n_q) || (b_q == '0);
		sts.p_one      = (p_q == WIDTH'(1));
		sts.p_eq_b     = (p_q == b_q);
		sts.k_lt_last  = (k_q < nm1);
		sts.k_le_last  = (k_q <= nm1);
		sts.mul_done   = busy_q && (cnt_q == CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.mul_start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= modulus;
			g_q <= base;
			b_q <= target;
		end
		if (cmd.init_p) begin
			p_q <= g_q;
			k_q <= WIDTH'(1);
		end
		if (cmd.mul_start) begin
			acc_q <= '0;
			gsh_q <= g_q;
		end else if (busy_q) begin
			acc_q <= step[WIDTH-1:0];
			gsh_q <= {gsh_q[WIDTH-2:0], 1'b0};
			if (cnt_q == CW'(1)) begin
				p_q <= step[WIDTH-1:0];
				k_q <= k_q + WIDTH'(1);
			end
		end
		if (cmd.res_load) begin
			status_q   <= cmd.res_status;
			exponent_q <= cmd.res_found ? k_q : '0;
		end
	end

	assign status   = status_q;
	assign exponent = exponent_q;

endmodule

@@ src/dls_ctrl.sv @@
// controller of the discrete log search: sequences the order check, the target
// check and the exhaustive search, and owns the response valid; uses dls_pkg
module dls_ctrl import dls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic out_ready,
	input  sts_t sts,
	output logic in_ready,
	output logic out_valid,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ORDER_TEST,
		S_ORDER_MUL,
		S_TARGET,
		S_SEARCH_TEST,
		S_SEARCH_MUL,
		S_FINISH
	} state_t;

	state_t  state_q;
	status_t status_q;
	logic    out_valid_q;
	logic    out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.res_status = status_q;
		cmd.res_found  = (status_q == ST_FOUND);
		unique case (state_q)
			S_IDLE:        cmd.load      = in_valid;
			S_CHECK:       cmd.init_p    = !sts.bad_base;
			S_ORDER_TEST:  cmd.mul_start = sts.k_lt_last && !sts.p_one;
			S_ORDER_MUL:   cmd.load      = 1'b0;
			S_TARGET:      cmd.init_p    = !sts.bad_target;
			S_SEARCH_TEST: cmd.mul_start = sts.k_le_last && !sts.p_eq_b;
			S_SEARCH_MUL:  cmd.load      = 1'b0;
			S_FINISH:      cmd.res_load  = out_free;
			default:       cmd.load      = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_NOT_GEN;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.bad_base) begin
						status_q <= ST_NOT_GEN;
						state_q  <= S_FINISH;
					end else begin
						state_q <= S_ORDER_TEST;
					end
				end
				S_ORDER_TEST: begin
					if (sts.k_lt_last) begin
						if (sts.p_one) begin
							status_q <= ST_NOT_GEN;
							state_q  <= S_FINISH;
						end else begin
							state_q <= S_ORDER_MUL;
						end
					end else if (sts.p_one) begin
						state_q <= S_TARGET;
					end else begin
						status_q <= ST_NOT_GEN;
						state_q  <= S_FINISH;
					end
				end
				S_ORDER_MUL: begin
					if (sts.mul_done) begin
						state_q <= S_ORDER_TEST;
					end
				end
				S_TARGET: begin
					if (sts.bad_target) begin
						status_q <= ST_BAD_TARGET;
						state_q  <= S_FINISH;
					end else begin
						state_q <= S_SEARCH_TEST;
					end
				end
				S_SEARCH_TEST: begin
					if (!sts.k_le_last) begin
						status_q <= ST_NOT_GEN;
						state_q  <= S_FINISH;
					end else if (sts.p_eq_b) begin
						status_q <= ST_FOUND;
						state_q  <= S_FINISH;
					end else begin
						state_q <= S_SEARCH_MUL;
					end
				end
				S_SEARCH_MUL: begin
					if (sts.mul_done) begin
						state_q <= S_SEARCH_TEST;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/discrete_log_search.sv @@
// Discrete logarithm by exhaustive search.
// req (sink): a word of modulus n, base g and target b, taken when valid and ready.
// rsp (source): a word of status (0 found, 1 base not a generator, 2 target out of
// range or zero) and exponent, the smallest x >= 1 with g^x mod n = b, else 0.
// One request is in work at a time; ready is high only while the block is idle.
// The base is first proven a generator by stepping g^k up to k = n-1, then the
// target is sought by stepping g^x again. Each step is one bit-serial modular
// multiply followed by a test state; a generator takes n-2 order multiplies and
// a found target x-1 search multiplies. When the base fails its range check the
// block goes straight from the check state to the finish state.
// After the finish state the block returns to idle, where the next request is taken.
// The result sits in an output register; a stalled receiver holds it there, and a
// following request that finishes meanwhile waits in the finish state until the
// held word is taken. Asynchronous reset returns the block to idle with no
// response pending.
module discrete_log_search import dls_pkg::*; #(
	parameter int WIDTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	dls_in_if.sink   req,
	dls_out_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	dls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	dls_dp #(.WIDTH(WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.modulus  (req.modulus),
		.base     (req.base),
		.target   (req.target),
		.cmd      (cmd),
		.sts      (sts),
		.status   (rsp.status),
		.exponent (rsp.exponent)
	);

endmodule

@@ src/dls_checker.sv @@
// port-level checks for discrete_log_search, attached by bind
// depends on dls_pkg and discrete_log_search_defines.svh
`include "discrete_log_search_defines.svh"

module dls_checker import dls_pkg::*; #(
	parameter int WIDTH = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [1:0]       rsp_status,
	input logic [WIDTH-1:0] rsp_exponent
);

	logic             stalled;
	logic [WIDTH+1:0] rsp_word;

	assign stalled  = rsp_valid && !rsp_ready;
	assign rsp_word = {rsp_status, rsp_exponent};

	`DLS_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_word), "stalled word changed")
	`DLS_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "word taken while busy")
	`DLS_ASSERT_NOW(a_error_zero, rsp_valid && (rsp_status != ST_FOUND), rsp_exponent == '0, "error word with exponent")
	`DLS_ASSERT_NOW(a_found_nonzero, rsp_valid && (rsp_status == ST_FOUND), rsp_exponent != '0, "found word, zero exponent")

endmodule

bind discrete_log_search dls_checker #(.WIDTH(WIDTH)) u_dls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_exponent (rsp.exponent)
);
